// ----- hdl/qtca_pkg.sv -----
// Package for the quantile tracker with centroid alarm.
// Holds sizes, register indexes and the reference tables; no dependencies.
package qtca_pkg;

  localparam int NumQuantiles = 11;
  localparam int NumCentroids = 5;
  localparam int FracBits     = 10;
  localparam int NumProfiles  = 3;
  localparam int TabCols      = 9;
  localparam int TabRows      = 5;
  localparam int TabQ         = 11;

  localparam int QW   = $clog2(NumQuantiles);
  localparam int CW   = $clog2(NumCentroids + NumProfiles);
  localparam int DW   = 36;
  localparam int EW   = 16;

  localparam logic [DW-1:0] DistMax = '1;

  typedef enum logic [1:0] {
    RegStepSize    = 2'd0,
    RegWindowCount = 2'd1,
    RegAlarmLimit  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic start_track;
    logic [QW-1:0] q_idx;
    logic [CW-1:0] row_idx;
    logic clr_acc;
    logic acc_en;
  } dp_cmd_t;

  function automatic logic [6:0] tau_pct(input int k);
    logic [6:0] t [TabQ] = '{7'd1, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50,
                             7'd60, 7'd70, 7'd80, 7'd90, 7'd99};
    int i;
    i = (k < TabQ) ? k : TabQ - 1;
    return t[i];
  endfunction

  // Rows 0..4 are centroids, rows 5..7 the stable, unstable and semistable profiles.
  localparam int signed RefTab [8][9] = '{
    '{124754, 115865, 106022, 96310, 85568, 76007, 62475, 39216, 4802},
    '{-127611, -140689, -152088, -162132, -172547, -185408, -200160, -213903, -229201},
    '{-54709, -67502, -78115, -90614, -101933, -116035, -132326, -150797, -180237},
    '{15438, 3049, -10858, -25667, -40349, -54095, -70205, -86187, -112204},
    '{84575, 64945, 48876, 35223, 18732, 4489, -13299, -34683, -71815},
    '{136256, 122821, 111293, 99779, 86658, 73695, 58642, 42854, 24052},
    '{378864, 290744, 236034, 201156, 178776, 160498, 140450, 120730, 99962},
    '{271214, 213497, 179424, 156225, 139277, 123575, 107073, 89686, 71408}
  };

  // Reference value rounded to FracBits, ties up.
  function automatic logic signed [19:0] ref_val(input logic [CW-1:0] row,
                                                 input logic [QW-1:0] k);
    int c, r, sh;
    logic signed [31:0] v;
    c = int'(k) - 2;
    if (c > TabCols - 1) c = TabCols - 1;
    if (c < 0) c = 0;
    r = (int'(row) < NumCentroids) ?
        ((int'(row) < TabRows) ? int'(row) : TabRows - 1) :
        int'(row) - NumCentroids + TabRows;
    sh = 16 - FracBits;
    v = RefTab[r][c];
    if (sh > 0) v = (v + (32'sd1 <<< (sh - 1))) >>> sh;
    return v[19:0];
  endfunction

endpackage

// ----- hdl/qtca_datapath.sv -----
// Datapath: tracker state, one shared squarer and the distance accumulator.
// Depends on qtca_pkg.
module qtca_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  qtca_pkg::dp_cmd_t     cmd_i,
  input  logic signed [15:0]    residual_i,
  input  logic [7:0]            step_size_i,
  input  logic [5:0]            window_count_i,
  output logic [qtca_pkg::DW-1:0] acc_o
);

  logic signed [15:0] est_q [qtca_pkg::NumQuantiles];
  logic [5:0]         above_q [qtca_pkg::NumQuantiles];
  logic [5:0]         below_q [qtca_pkg::NumQuantiles];
  logic signed [15:0] est_sel;
  logic signed [15:0] est_d;
  logic [5:0]         n_d, m_d;
  logic [12:0]        n_x, m_x, w_p, w_q;
  logic [6:0]         p;
  logic signed [17:0] e_wide;
  logic signed [20:0] diff;
  logic [20:0]        mag_q;
  logic               mag_vld_q;
  logic [41:0]        prod;
  logic [42:0]        sum;
  logic [qtca_pkg::DW-1:0] acc_q;

  assign est_sel = est_q[cmd_i.q_idx];
  assign p = qtca_pkg::tau_pct(int'(cmd_i.q_idx));

  always_comb begin
    n_d = above_q[cmd_i.q_idx];
    m_d = below_q[cmd_i.q_idx];
    est_d = est_sel;
    if (residual_i >= est_sel) n_d = n_d + 6'd1;
    else m_d = m_d + 6'd1;
    n_x = 13'(n_d) * 13'd100;
    m_x = 13'(m_d) * 13'd100;
    w_p = 13'(window_count_i) * 13'(p);
    w_q = 13'(window_count_i) * 13'(7'd100 - p);
    e_wide = 18'(est_sel);
    if (n_x > w_p) begin
      e_wide = e_wide + 18'(step_size_i);
      n_d = '0; m_d = '0;
    end else if (m_x > w_q) begin
      e_wide = e_wide - 18'(step_size_i);
      n_d = '0; m_d = '0;
    end else if (7'(n_d) + 7'(m_d) == 7'(window_count_i)) begin
      n_d = '0; m_d = '0;
    end
    if (e_wide > 18'sd32767) est_d = 16'sh7fff;
    else if (e_wide < -18'sd32768) est_d = 16'sh8000;
    else est_d = e_wide[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < qtca_pkg::NumQuantiles; i++) begin
        est_q[i] <= '0; above_q[i] <= '0; below_q[i] <= '0;
      end
    end else if (cmd_i.start_track) begin
      est_q[cmd_i.q_idx]   <= est_d;
      above_q[cmd_i.q_idx] <= n_d;
      below_q[cmd_i.q_idx] <= m_d;
    end
  end

  // Difference stage, then the square in the next cycle.
  assign diff = 21'(est_sel) - 21'(qtca_pkg::ref_val(cmd_i.row_idx, cmd_i.q_idx));
  assign prod = 42'(mag_q) * 42'(mag_q);
  assign sum  = 43'(acc_q) + 43'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_vld_q <= 1'b0;
      acc_q     <= '0;
    end else begin
      mag_vld_q <= cmd_i.acc_en;
      if (cmd_i.clr_acc) acc_q <= '0;
      else if (mag_vld_q) acc_q <= (sum[42:36] != '0) ? qtca_pkg::DistMax : sum[35:0];
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= diff[20] ? 21'(-diff) : 21'(diff);
  end

  assign acc_o = acc_q;

endmodule

// ----- hdl/qtca_ctrl.sv -----
// Controller: sequences tracker updates, distance sums and the result.
// Depends on qtca_pkg.
module qtca_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic                  pos_i,
  input  logic [qtca_pkg::DW-1:0] acc_i,
  input  logic [qtca_pkg::DW-1:0] alarm_limit_i,
  output qtca_pkg::dp_cmd_t     cmd_o,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output logic [qtca_pkg::DW+3:0] m_data_o
);

  typedef enum logic [2:0] {StIdle, StTrack, StDist, StDrain, StRow, StOut} state_e;

  localparam logic [qtca_pkg::CW-1:0] LastRow =
    qtca_pkg::CW'(qtca_pkg::NumCentroids + qtca_pkg::NumProfiles - 1);
  localparam logic [qtca_pkg::QW-1:0] LastQ = qtca_pkg::QW'(qtca_pkg::NumQuantiles - 1);

  state_e state_q;
  logic [qtca_pkg::QW-1:0] q_q;
  logic [qtca_pkg::CW-1:0] row_q;
  logic [1:0]  drain_q;
  logic        upd_q;
  logic [qtca_pkg::DW-1:0] min_q, best_q;
  logic [1:0]  cls_q;
  logic        m_valid_q;
  logic [qtca_pkg::DW+3:0] m_data_q;
  logic        is_cent;

  assign is_cent = row_q < qtca_pkg::CW'(qtca_pkg::NumCentroids);
  // The output register parts the two sides: a waiting result holds only StOut.
  assign s_ready_o = (state_q == StIdle);

  always_comb begin
    cmd_o = '0;
    cmd_o.q_idx = q_q;
    cmd_o.row_idx = row_q;
    cmd_o.start_track = (state_q == StTrack);
    cmd_o.acc_en = (state_q == StDist);
    cmd_o.clr_acc = (state_q == StRow);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; q_q <= '0; row_q <= '0; drain_q <= '0; upd_q <= 1'b0;
      min_q <= '0; best_q <= '0; cls_q <= '0; m_valid_q <= 1'b0; m_data_q <= '0;
    end else begin
      if (m_valid_q && m_ready_i) m_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: if (s_valid_i && s_ready_o) begin
          upd_q <= pos_i;
          min_q <= qtca_pkg::DistMax;
          q_q <= pos_i ? '0 : qtca_pkg::QW'(2);
          row_q <= pos_i ? '0 : qtca_pkg::CW'(qtca_pkg::NumCentroids);
          state_q <= pos_i ? StTrack : StDist;
        end
        StTrack: begin
          if (q_q == LastQ) begin q_q <= qtca_pkg::QW'(2); state_q <= StDist; end
          else q_q <= q_q + qtca_pkg::QW'(1);
        end
        StDist: begin
          if (q_q == LastQ) begin drain_q <= '0; state_q <= StDrain; end
          else q_q <= q_q + qtca_pkg::QW'(1);
        end
        StDrain: begin
          drain_q <= drain_q + 2'd1;
          if (drain_q == 2'd1) state_q <= StRow;
        end
        StRow: begin
          if (is_cent) begin
            if (acc_i < min_q) min_q <= acc_i;
          end else if (row_q == qtca_pkg::CW'(qtca_pkg::NumCentroids) || acc_i < best_q) begin
            best_q <= acc_i;
            cls_q <= 2'(row_q - qtca_pkg::CW'(qtca_pkg::NumCentroids));
          end
          q_q <= qtca_pkg::QW'(2);
          if (row_q == LastRow) state_q <= StOut;
          else begin row_q <= row_q + qtca_pkg::CW'(1); state_q <= StDist; end
        end
        StOut: if (!m_valid_q) begin
          m_valid_q <= 1'b1;
          m_data_q <= {cls_q, upd_q && (min_q > alarm_limit_i),
                       upd_q ? min_q : {qtca_pkg::DW{1'b0}}, upd_q};
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o = m_data_q;

endmodule

// ----- hdl/quantile_tracker_centroid_alarm.sv -----
// Channel   | Group   | Payload (low bit first)
// input     | s_axis  | tdata: residual[15:0]
// output    | m_axis  | tdata: updated, min_sq_dist[35:0], alarm, stability_class[1:0]
// config    | cfg     | index 0 step_size, 1 window_count, 2 alarm_limit
// A positive residual first steps every quantile tracker, then scores 8 rows, each as
// 9 squared differences, a pipeline drain and a compare, and then writes the result;
// the controller then returns to idle and takes the next transaction.
// A zero or negative residual only scores the 3 profiles. One item is in work at a
// time; a stalled result holds the controller only when the next result is ready.
// Asynchronous reset clears trackers and controller state and loads config defaults.
module quantile_tracker_centroid_alarm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // residual
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // updated, min_sq_dist, alarm, stability_class
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [35:0] cfg_data_i
);

  logic [7:0]  step_q;
  logic [5:0]  win_q;
  logic [35:0] lim_q;
  logic signed [15:0] res_q;
  logic        pos;
  qtca_pkg::dp_cmd_t cmd;
  logic [qtca_pkg::DW-1:0] acc;

  assign pos = !s_axis_tdata[15] && (s_axis_tdata != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 8'd20; win_q <= 6'd10; lim_q <= 36'd5308416; res_q <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) res_q <= s_axis_tdata;
      if (cfg_we_i) begin
        unique case (qtca_pkg::reg_idx_e'(cfg_idx_i))
          qtca_pkg::RegStepSize:    step_q <= cfg_data_i[7:0];
          qtca_pkg::RegWindowCount: win_q <= cfg_data_i[5:0];
          qtca_pkg::RegAlarmLimit:  lim_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  qtca_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .residual_i(res_q),
    .step_size_i(step_q), .window_count_i(win_q), .acc_o(acc)
  );

  qtca_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready),
    .pos_i(pos), .acc_i(acc), .alarm_limit_i(lim_q), .cmd_o(cmd),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_o(m_axis_tdata)
  );

  a_noupd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[37:1] == '0) else $error("no-update result");
  a_cls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:38] != 2'd3) else $error("bad class");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("accepted while busy");

endmodule
